// ===== design/fspt_pkg.sv =====
// Shared types and constants for the binary32 power-of-two scaling pipeline.
`default_nettype none
package fspt_pkg;

    localparam logic [7:0]  FIELD_MAX  = 8'hFF;
    localparam logic [8:0]  EXP_BIAS   = 9'd127;
    localparam int          MANT_BITS  = 23;
    localparam int          SIG_BITS   = MANT_BITS + 1;
    localparam logic [30:0] MAX_FINITE = 31'h7F7FFFFF;

    typedef enum logic
    {
        CMD_LDEXP = 1'b0,
        CMD_FREXP = 1'b1
    } cmd_t;

    // Word after the first stage: operand split up, scale chosen, lead count known.
    typedef struct packed
    {
        logic                sign;
        logic                zero;
        logic                sat;
        logic [SIG_BITS-1:0] sig;
        logic [7:0]          field;
        logic signed [9:0]   scale;
        logic [4:0]          lead;
        logic signed [8:0]   extracted;
    } dec_t;

    // Word after the second stage: significand normalized, final exponent known.
    typedef struct packed
    {
        logic                sign;
        logic                zero;
        logic                sat;
        logic [SIG_BITS-1:0] sig;
        logic signed [10:0]  expo;
        logic signed [8:0]   extracted;
    } norm_t;

endpackage
`default_nettype wire

// ===== design/float_scale_by_power_of_two.sv =====
// Path: a word taken with start is registered in turn by the decode and lead count,
// normalize and pack stages, then appears on the result ports, marked by done.
// Throughput: one word per cycle; busy stays low, since every stage is a plain
// register with a valid bit and the result side takes every word.
// Reset: rst_n clears all valid bits asynchronously; no word is in flight after it.
`default_nettype none
module float_scale_by_power_of_two
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               command,
    input  wire logic [31:0]        value_bits,
    input  wire logic signed [9:0]  scale_exponent,
    output logic                    done,
    output logic [31:0]             result_bits,
    output logic signed [8:0]       extracted_exponent
);
    import fspt_pkg::*;

    dec_t  dec_word;
    logic  dec_valid;
    norm_t norm_word;
    logic  norm_valid;
    logic  accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    fspt_decode u_decode
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (accept),
        .command        (command),
        .value_bits     (value_bits),
        .scale_exponent (scale_exponent),
        .dec_out        (dec_word),
        .dec_valid      (dec_valid)
    );

    fspt_normalize u_normalize
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .dec_in     (dec_word),
        .dec_valid  (dec_valid),
        .norm_out   (norm_word),
        .norm_valid (norm_valid)
    );

    fspt_pack u_pack
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .norm_in            (norm_word),
        .norm_valid         (norm_valid),
        .result_bits        (result_bits),
        .extracted_exponent (extracted_exponent),
        .done               (done)
    );

endmodule
`default_nettype wire

// ===== design/fspt_decode.sv =====
// First stage: operand decode, scale selection and leading-zero count.
`default_nettype none
module fspt_decode
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               command,
    input  wire logic [31:0]        value_bits,
    input  wire logic signed [9:0]  scale_exponent,
    output fspt_pkg::dec_t          dec_out,
    output logic                    dec_valid
);
    import fspt_pkg::*;

    logic [7:0]          field;
    logic [22:0]         mant;
    logic [SIG_BITS-1:0] sig;
    logic [4:0]          lead;
    logic signed [8:0]   extracted;
    logic signed [9:0]   scale;
    dec_t                dec_next;
    dec_t                dec_reg;
    logic                valid_next;
    logic                valid_reg;

    assign field = value_bits[30:23];
    assign mant  = value_bits[22:0];
    assign sig   = {(field != 8'd0), mant};

    // Priority encoder: the highest set bit wins, giving the left shift
    // that brings it up to the hidden-bit position.
    always_comb
    begin
        lead = 5'd0;
        for (int i = 0; i < SIG_BITS; i++)
        begin
            if (sig[i])
            begin
                lead = 5'(SIG_BITS - 1 - i);
            end
        end
    end

    always_comb
    begin
        if (cmd_t'(command) == CMD_FREXP)
        begin
            extracted = $signed({1'b0, field} - EXP_BIAS);
            scale     = $signed(10'd127 - {2'b00, field});
        end
        else
        begin
            extracted = 9'sd0;
            scale     = scale_exponent;
        end
    end

    always_comb
    begin
        dec_next.sign      = value_bits[31];
        dec_next.zero      = (field == 8'd0) && (mant == 23'd0);
        dec_next.sat       = (field == FIELD_MAX);
        dec_next.sig       = sig;
        // A subnormal sits at the same scale as field one.
        dec_next.field     = (field == 8'd0) ? 8'd1 : field;
        dec_next.scale     = scale;
        dec_next.lead      = lead;
        dec_next.extracted = extracted;
        valid_next         = in_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
    end

    assign dec_out   = dec_reg;
    assign dec_valid = valid_reg;

endmodule
`default_nettype wire

// ===== design/fspt_normalize.sv =====
// Second stage: left-normalizes the significand and forms the result exponent.
`default_nettype none
module fspt_normalize
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  fspt_pkg::dec_t      dec_in,
    input  wire logic           dec_valid,
    output fspt_pkg::norm_t     norm_out,
    output logic                norm_valid
);
    import fspt_pkg::*;

    norm_t norm_next;
    norm_t norm_reg;
    logic  valid_next;
    logic  valid_reg;

    always_comb
    begin
        norm_next.sign      = dec_in.sign;
        norm_next.zero      = dec_in.zero;
        norm_next.sat       = dec_in.sat;
        norm_next.sig       = dec_in.sig << dec_in.lead;
        norm_next.expo      = $signed({3'b000, dec_in.field})
                            + $signed({dec_in.scale[9], dec_in.scale})
                            - $signed({6'b000000, dec_in.lead});
        norm_next.extracted = dec_in.extracted;
        valid_next          = dec_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        norm_reg <= norm_next;
    end

    assign norm_out   = norm_reg;
    assign norm_valid = valid_reg;

endmodule
`default_nettype wire

// ===== design/fspt_pack.sv =====
// Third stage: saturation, subnormal right shift and packing of the result word.
`default_nettype none
module fspt_pack
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  fspt_pkg::norm_t     norm_in,
    input  wire logic           norm_valid,
    output logic [31:0]         result_bits,
    output logic signed [8:0]   extracted_exponent,
    output logic                done
);
    import fspt_pkg::*;

    logic signed [10:0] rshift;
    logic [SIG_BITS-1:0] denorm;
    logic [31:0]        result_next;
    logic [31:0]        result_reg;
    logic signed [8:0]  extracted_reg;
    logic               done_next;
    logic               done_reg;

    assign rshift = 11'sd1 - norm_in.expo;

    // Any shift of a full significand width or more leaves nothing.
    always_comb
    begin
        if (rshift >= 11'sd24)
        begin
            denorm = '0;
        end
        else
        begin
            denorm = norm_in.sig >> rshift[4:0];
        end
    end

    always_comb
    begin
        if (norm_in.zero)
        begin
            result_next = {norm_in.sign, 31'd0};
        end
        else if (norm_in.sat || (norm_in.expo >= 11'sd255))
        begin
            result_next = {norm_in.sign, MAX_FINITE};
        end
        else if (norm_in.expo >= 11'sd1)
        begin
            result_next = {norm_in.sign, norm_in.expo[7:0], norm_in.sig[MANT_BITS-1:0]};
        end
        else
        begin
            result_next = {norm_in.sign, 8'd0, denorm[MANT_BITS-1:0]};
        end
        done_next = norm_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg    <= result_next;
        extracted_reg <= norm_in.extracted;
    end

    assign result_bits        = result_reg;
    assign extracted_exponent = extracted_reg;
    assign done               = done_reg;

endmodule
`default_nettype wire
